### rtl/lrod_pkg.sv
// Package for the lidar region obstacle detector.
// Holds register indexes, field widths, shared structs and the quarter-wave sine builder.
// No dependencies.
`default_nettype none

package lrod_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned RangeW  = 16;
  localparam int unsigned AngleW  = 16;
  localparam int unsigned StepW   = 12;
  localparam int unsigned CountW  = 13;
  localparam int unsigned StreakW = 8;
  localparam int unsigned MagW    = 15;  // |sin| magnitude, Q15 scaled by 32767
  localparam int unsigned ProdW   = RangeW + MagW;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  // Inside-count ceiling
  localparam int unsigned MaxScanPoints = 4096;
  localparam int unsigned CountCapInt   = (MaxScanPoints < 8191) ? MaxScanPoints : 8191;
  localparam logic [CountW-1:0] CountCap = CountW'(CountCapInt);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegScanStart   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegScanStep    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRegionAngle = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLength      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWidth       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMinPoints   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRepeat      = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCountMisses = 3'd7;

  localparam logic [CountW-1:0]  MinPointsRst = 13'd50;
  localparam logic [StreakW-1:0] RepeatRst    = 8'd3;

  localparam logic [63:0] HalfPiQ62 = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic [AngleW-1:0]  base_angle;   // scan start minus region angle
    logic [StepW-1:0]   step;
    logic [ProdW-1:0]   len_lim;      // length * 32767
    logic [ProdW-1:0]   wid_lim;      // width * 32767
    logic [CountW-1:0]  min_points;
    logic [StreakW-1:0] repeat_count;
    logic               miss_mode;
  } cfg_t;

  // Sample word leaving the geometry pipe
  typedef struct packed {
    logic valid;
    logic in_rect;
    logic last;
  } item_t;

  // (a*b) >> s, full product
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> s);
  endfunction

  // term / ((2k)(2k+1)) for the sine series
  function automatic logic [63:0] fact_div(logic [63:0] term, int unsigned k);
    logic [63:0] q;
    case (k)
      1:       q = term / 64'd6;
      2:       q = term / 64'd20;
      3:       q = term / 64'd42;
      4:       q = term / 64'd72;
      5:       q = term / 64'd110;
      6:       q = term / 64'd156;
      7:       q = term / 64'd210;
      8:       q = term / 64'd272;
      9:       q = term / 64'd342;
      10:      q = term / 64'd420;
      11:      q = term / 64'd506;
      12:      q = term / 64'd600;
      13:      q = term / 64'd702;
      default: q = term;
    endcase
    return q;
  endfunction

  // round(32767*sin(pi/2 * j / 2^(bits-2))), elaboration only
  function automatic logic [MagW-1:0] quarter_sine(int unsigned j, int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] res;
    x    = mul_shift(HalfPiQ62, 64'(j), bits - 2);
    x2   = mul_shift(x, x, 62);
    term = x;
    sum  = x;
    for (int unsigned k = 1; k <= 13; k++) begin
      term = fact_div(mul_shift(term, x2, 62), k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    res = (((sum >> 20) * 64'd32767) + (64'd1 << 41)) >> 42;
    return MagW'(res);
  endfunction

endpackage

`default_nettype wire

### rtl/lrod_cfg.sv
// Configuration register file for the obstacle detector.
// Uses lrod_pkg; derives the angle base and the scaled region limits.
`default_nettype none

module lrod_cfg import lrod_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t                    cfg_o,
  output logic                    reload_o,
  output logic [AngleW-1:0]       reload_angle_o
);

  logic [AngleW-1:0]  start_q, region_q;
  logic [StepW-1:0]   step_q;
  logic [RangeW-1:0]  len_q, wid_q;
  logic [CountW-1:0]  min_q;
  logic [StreakW-1:0] rep_q;
  logic               miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      region_q <= '0;
      step_q   <= '0;
      len_q    <= '0;
      wid_q    <= '0;
      min_q    <= MinPointsRst;
      rep_q    <= RepeatRst;
      miss_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegScanStart:   start_q  <= cfg_wdata_i[AngleW-1:0];
          RegScanStep:    step_q   <= cfg_wdata_i[StepW-1:0];
          RegRegionAngle: region_q <= cfg_wdata_i[AngleW-1:0];
          RegLength:      len_q    <= cfg_wdata_i[RangeW-1:0];
          RegWidth:       wid_q    <= cfg_wdata_i[RangeW-1:0];
          RegMinPoints:   min_q    <= cfg_wdata_i[CountW-1:0];
          RegRepeat:      rep_q    <= cfg_wdata_i[StreakW-1:0];
          RegCountMisses: miss_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // x*32767 = (x << 15) - x
  always_comb begin
    cfg_o.base_angle   = start_q - region_q;
    cfg_o.step         = step_q;
    cfg_o.len_lim      = {len_q, 15'd0} - ProdW'(len_q);
    cfg_o.wid_lim      = {wid_q, 15'd0} - ProdW'(wid_q);
    cfg_o.min_points   = min_q;
    cfg_o.repeat_count = rep_q;
    cfg_o.miss_mode    = miss_q;
  end

  // start or region write reloads the sample angle at the write edge itself
  assign reload_o = cfg_we_i && (cfg_idx_i == RegScanStart || cfg_idx_i == RegRegionAngle);
  assign reload_angle_o = (cfg_idx_i == RegScanStart) ? cfg_wdata_i[AngleW-1:0] - region_q
                                                      : start_q - cfg_wdata_i[AngleW-1:0];

endmodule

`default_nettype wire

### rtl/lrod_geom.sv
// Geometry pipe: sample angle generation, quarter-wave sin/cos lookup,
// range products and rectangle test. Uses lrod_pkg.
`default_nettype none

module lrod_geom import lrod_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  cfg_t                   cfg_i,
  input  wire logic              reload_i,
  input  wire logic [AngleW-1:0] reload_angle_i,
  input  wire logic              adv_i,
  input  wire logic              acc_i,
  input  wire logic [RangeW-1:0] range_i,
  input  wire logic              ok_i,
  input  wire logic              last_i,
  output item_t                  item_o
);

  localparam int unsigned IdxW    = SINE_TABLE_BITS;
  localparam int unsigned QaW     = SINE_TABLE_BITS - 1;
  localparam int unsigned Quarter = 1 << (SINE_TABLE_BITS - 2);

  // quarter-wave magnitude table, entries 0..Quarter
  logic [MagW-1:0] qtab [Quarter+1];

  for (genvar j = 0; j <= Quarter; j++) begin : g_tab
    localparam logic [MagW-1:0] Val = quarter_sine(j, SINE_TABLE_BITS);
    assign qtab[j] = Val;
  end

  logic [AngleW-1:0] angle_q;

  // stage 1: registered sample
  logic              valid1_q, ok1_q, last1_q;
  logic [RangeW-1:0] rng1_q;
  logic [IdxW-1:0]   idx1_q;

  // stage 2: products
  logic             valid2_q, ok2_q, last2_q;
  logic [ProdW-1:0] prod_c_q, prod_s_q;

  // stage 3: test result
  logic valid3_q, in3_q, last3_q;

  logic              q_odd;
  logic [QaW-1:0]    rr, sin_addr, cos_addr;
  logic [MagW-1:0]   mag_s, mag_c;
  logic              in_x, in_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (reload_i) begin
      angle_q <= reload_angle_i;
    end else if (acc_i) begin
      angle_q <= last_i ? cfg_i.base_angle : angle_q + AngleW'(cfg_i.step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (adv_i) begin
      valid1_q <= acc_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rng1_q   <= range_i;
      ok1_q    <= ok_i;
      last1_q  <= last_i;
      idx1_q   <= angle_q[AngleW-1 -: IdxW];
      ok2_q    <= ok1_q;
      last2_q  <= last1_q;
      prod_c_q <= ProdW'(rng1_q) * ProdW'(mag_c);
      prod_s_q <= ProdW'(rng1_q) * ProdW'(mag_s);
      in3_q    <= ok2_q && in_x && in_y;
      last3_q  <= last2_q;
    end
  end

  // mirror into the first quarter; cos sits one quarter ahead
  always_comb begin
    q_odd    = idx1_q[IdxW-2];
    rr       = {1'b0, idx1_q[IdxW-3:0]};
    sin_addr = q_odd ? QaW'(Quarter) - rr : rr;
    cos_addr = q_odd ? rr : QaW'(Quarter) - rr;
    mag_s    = qtab[sin_addr];
    mag_c    = qtab[cos_addr];
  end

  assign in_x = prod_c_q < cfg_i.len_lim;
  assign in_y = {prod_s_q, 1'b0} < {1'b0, cfg_i.wid_lim};

  assign item_o.valid   = valid3_q;
  assign item_o.in_rect = in3_q;
  assign item_o.last    = last3_q;

endmodule

`default_nettype wire

### rtl/lrod_eval.sv
// Scan evaluation: inside counter, hit/miss streak and the result register.
// Uses lrod_pkg; drives the pipe stall back to the geometry stages.
`default_nettype none

module lrod_eval import lrod_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cfg_t                    cfg_i,
  input  item_t                   item_i,
  output logic                    adv_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    flag_o,
  output logic [CountW-1:0]       points_o,
  output logic [StreakW-1:0]      streak_o
);

  logic [CountW-1:0]  cnt_q, cnt_nxt;
  logic [StreakW-1:0] streak_q, streak_nxt;
  logic               out_valid_q, flag_q;
  logic [CountW-1:0]  points_q;
  logic               retire, fin, hit;

  // only a scan-end word needs the result register
  assign adv_o  = !(item_i.valid && item_i.last && out_valid_q && !out_ready_i);
  assign retire = item_i.valid && adv_o;
  assign fin    = retire && item_i.last;

  always_comb begin
    cnt_nxt = cnt_q;
    if (item_i.in_rect && cnt_q < CountCap) begin
      cnt_nxt = cnt_q + 1'b1;
    end
    hit = (cnt_nxt >= cfg_i.min_points) ^ cfg_i.miss_mode;
    if (!hit) begin
      streak_nxt = '0;
    end else if (streak_q != '1) begin
      streak_nxt = streak_q + 1'b1;
    end else begin
      streak_nxt = streak_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      streak_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (retire) begin
        cnt_q <= item_i.last ? '0 : cnt_nxt;
      end
      if (fin) begin
        streak_q    <= streak_nxt;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      flag_q   <= streak_nxt >= cfg_i.repeat_count;
      points_q <= cnt_nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign flag_o      = flag_q;
  assign points_o    = points_q;
  assign streak_o    = streak_q;

endmodule

`default_nettype wire

### rtl/lidar_region_obstacle_detect.sv
// Top level of the lidar region obstacle detector.
// Uses lrod_pkg, lrod_cfg, lrod_geom and lrod_eval.
//
//  port group   dir  width          contents (low bit first)
//  s_axis       in   16 + 1 + 1     tdata: range_mm; tuser: range_valid; tlast: scan_end
//  m_axis       out  24             tdata: obstacle_flag, points_inside, streak, 2'b0
//  cfg          in   3 idx, 16 data one register per write, index = register number
//
// One sample word per cycle while s_axis_tready is high; the scan-end word passes the input
// register, product stage, test stage and result register before m_axis_tvalid rises.
// Reset clears the counters, the angle and the registers (min_points 50, repeat_count 3).
// A waiting result stalls the pipe only when a further scan-end word reaches the count stage;
// other sample words keep flowing.
`default_nettype none

module lidar_region_obstacle_detect import lrod_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,   // range_mm
  input  wire logic               s_axis_tuser,   // range_valid
  input  wire logic               s_axis_tlast,   // scan_end
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [23:0]             m_axis_tdata,   // obstacle_flag, points_inside[12:0], streak[7:0]
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t               cfg;
  item_t              item;
  logic               reload, adv, acc;
  logic [AngleW-1:0]  reload_angle;
  logic               flag;
  logic [CountW-1:0]  points;
  logic [StreakW-1:0] streak;

  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  lrod_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cfg_o          (cfg),
    .reload_o       (reload),
    .reload_angle_o (reload_angle)
  );

  lrod_geom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_geom (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .reload_i       (reload),
    .reload_angle_i (reload_angle),
    .adv_i          (adv),
    .acc_i          (acc),
    .range_i        (s_axis_tdata),
    .ok_i           (s_axis_tuser),
    .last_i         (s_axis_tlast),
    .item_o         (item)
  );

  lrod_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .flag_o      (flag),
    .points_o    (points),
    .streak_o    (streak)
  );

  assign m_axis_tdata = {2'b00, streak, points, flag};

endmodule

`default_nettype wire

### tb/sv/tb_lidar_region_obstacle_detect.sv
// Self-checking testbench for lidar_region_obstacle_detect: drives scan samples with random
// gaps and back-pressure, predicts each scan result in-line and checks the result stream.
// Depends on lrod_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb_lidar_region_obstacle_detect;
  import lrod_pkg::*;

  localparam int TableBits   = 10;
  localparam int TableN      = 1 << TableBits;
  localparam int QuarterN    = TableN / 4;
  localparam int AngleShift  = 16 - TableBits;
  localparam int DrainCycles = 10;
  localparam int StallLimit  = 2000;
  localparam int RandomItems = 1450;
  localparam real QuarterTurnRad = 1.5707963267948966;

  typedef struct {
    logic [15:0] range_mm;
    logic        valid;
    logic        last;
  } sample_t;

  typedef struct {
    logic               flag;
    logic [CountW-1:0]  points;
    logic [StreakW-1:0] streak;
  } scan_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgW-1:0]    cfg_wdata_i   = '0;

  lidar_region_obstacle_detect #(
    .SINE_TABLE_BITS(TableBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // range_mm
    .s_axis_tuser (s_axis_tuser),   // range_valid
    .s_axis_tlast (s_axis_tlast),   // scan_end
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // obstacle_flag, points_inside[12:0], streak[7:0], pad
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow registers and scan state
  logic [15:0]        cfg_start, cfg_region, cfg_len, cfg_wid;
  logic [StepW-1:0]   cfg_step;
  logic [CountW-1:0]  cfg_min;
  logic [StreakW-1:0] cfg_rep;
  logic               cfg_miss;
  logic [15:0]        sweep_angle;
  logic [CountW-1:0]  inside_cnt;
  logic [StreakW-1:0] streak_cnt;
  int                 sin_mag [TableN];

  sample_t      pending_samples[$];
  scan_result_t expected_scans[$];
  int queued_cnt    = 0;
  int accepted_cnt  = 0;
  int scans_checked = 0;
  int error_cnt     = 0;
  int setting_cnt   = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 33;
  int stall_cycles  = 0;

  function automatic void advance_sweep(logic [15:0] range_mm, logic valid, logic last);
    int unsigned       idx;
    longint unsigned   r, s_abs, c_abs, len_lim, wid_lim;
    logic              hit;
    scan_result_t      res;
    if (valid) begin
      idx     = sweep_angle >> AngleShift;
      s_abs   = sin_mag[idx];
      c_abs   = sin_mag[(idx + QuarterN) % TableN];
      r       = range_mm;
      len_lim = cfg_len;
      wid_lim = cfg_wid;
      if (r * c_abs < len_lim * 32767 && 2 * r * s_abs < wid_lim * 32767 &&
          inside_cnt < CountCap) begin
        inside_cnt = inside_cnt + 1'b1;
      end
    end
    sweep_angle = sweep_angle + 16'(cfg_step);
    if (last) begin
      hit = (inside_cnt >= cfg_min) ^ cfg_miss;
      if (!hit) begin
        streak_cnt = '0;
      end else if (streak_cnt != 8'hFF) begin
        streak_cnt = streak_cnt + 1'b1;
      end
      res.flag   = streak_cnt >= cfg_rep;
      res.points = inside_cnt;
      res.streak = streak_cnt;
      expected_scans.insert(expected_scans.size(), res);
      inside_cnt  = '0;
      sweep_angle = cfg_start - cfg_region;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_cnt < 40) begin
      $display("MISMATCH scan %0d %s: got %0d expected %0d", scans_checked, what, got, want);
    end
    error_cnt++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegScanStart:   cfg_start  = val;
      RegScanStep:    cfg_step   = val[StepW-1:0];
      RegRegionAngle: cfg_region = val;
      RegLength:      cfg_len    = val;
      RegWidth:       cfg_wid    = val;
      RegMinPoints:   cfg_min    = val[CountW-1:0];
      RegRepeat:      cfg_rep    = val[StreakW-1:0];
      RegCountMisses: cfg_miss   = val[0];
      default: ;
    endcase
    // angle writes restart the sweep, the count survives
    if (idx == RegScanStart || idx == RegRegionAngle) sweep_angle = cfg_start - cfg_region;
  endtask

  task automatic add_sample(logic [15:0] range_mm, logic valid, logic last);
    sample_t s;
    s.range_mm = range_mm;
    s.valid    = valid;
    s.last     = last;
    pending_samples.insert(pending_samples.size(), s);
    queued_cnt++;
  endtask

  task automatic wait_idle();
    while (queued_cnt != accepted_cnt || expected_scans.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_range();
    int lim;
    int sel;
    lim = (cfg_len > cfg_wid) ? cfg_len : cfg_wid;
    lim = (2 * lim > 65535) ? 65535 : 2 * lim;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (sel <= 2) return 16'($urandom);
    return 16'($urandom_range(0, lim));
  endfunction

  function automatic logic [15:0] pick_setting(logic [CfgIdxW-1:0] idx);
    logic corner;
    logic coin;
    corner = $urandom_range(0, 99) < 15;
    coin   = $urandom_range(0, 1);
    case (idx)
      RegScanStart, RegRegionAngle:
        return corner ? (coin ? 16'h8000 : 16'h7FFF) : 16'($urandom);
      RegScanStep:
        return corner ? (coin ? 16'd0 : 16'd4095) : 16'($urandom_range(0, 4095));
      RegLength, RegWidth:
        return corner ? (coin ? 16'd0 : 16'hFFFF) :
               (coin ? 16'($urandom_range(0, 4000)) : 16'($urandom));
      RegMinPoints:
        return corner ? (coin ? 16'd0 : 16'd4096) : 16'($urandom_range(0, 24));
      RegRepeat:
        return corner ? (coin ? 16'd0 : 16'd255) : 16'($urandom_range(0, 4));
      default:
        return 16'(coin);
    endcase
  endfunction

  task automatic maybe_write(logic [CfgIdxW-1:0] idx);
    if ($urandom_range(0, 3) != 0) write_reg(idx, pick_setting(idx));
  endtask

  task automatic shuffle_settings();
    maybe_write(RegScanStart);
    maybe_write(RegScanStep);
    maybe_write(RegRegionAngle);
    maybe_write(RegLength);
    maybe_write(RegWidth);
    maybe_write(RegMinPoints);
    maybe_write(RegRepeat);
    maybe_write(RegCountMisses);
    setting_cnt++;
  endtask

  // Sender: one word per handshake, random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive_samples
    sample_t word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_sweep(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          word = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= word.range_mm;
          s_axis_tuser  <= word.valid;
          s_axis_tlast  <= word.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, field-by-field compare
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    scan_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_scans.size() == 0) begin
          report_mismatch("result with nothing expected, word", m_axis_tdata, -1);
        end else begin
          want = expected_scans.pop_front();
          if (m_axis_tdata[0] !== want.flag)
            report_mismatch("obstacle_flag", m_axis_tdata[0], want.flag);
          if (m_axis_tdata[13:1] !== want.points)
            report_mismatch("points_inside", m_axis_tdata[13:1], want.points);
          if (m_axis_tdata[21:14] !== want.streak)
            report_mismatch("streak", m_axis_tdata[21:14], want.streak);
        end
        scans_checked++;
      end
      m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Watchdog: no word moved for %0d cycles", StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int j;
    int scan_len;
    int random_items;
    for (int i = 0; i < TableN; i++) begin
      j = i % QuarterN;
      if ((i / QuarterN) % 2 == 1) j = QuarterN - j;
      sin_mag[i] = int'($floor(32767.0 * $sin(QuarterTurnRad * j / QuarterN) + 0.5));
    end
    cfg_start   = '0;
    cfg_step    = '0;
    cfg_region  = '0;
    cfg_len     = '0;
    cfg_wid     = '0;
    cfg_min     = MinPointsRst;
    cfg_rep     = RepeatRst;
    cfg_miss    = 1'b0;
    sweep_angle = '0;
    inside_cnt  = '0;
    streak_cnt  = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: empty region, min_points 50
    add_sample(16'd1000, 1'b1, 1'b0);
    add_sample(16'd0, 1'b1, 1'b1);
    add_sample(16'hFFFF, 1'b0, 1'b1);
    wait_idle();

    // Widest region, every scan a hit, flag always set
    write_reg(RegScanStart, 16'h8000);
    write_reg(RegScanStep, 16'd4095);
    write_reg(RegRegionAngle, 16'h7FFF);
    write_reg(RegLength, 16'hFFFF);
    write_reg(RegWidth, 16'hFFFF);
    write_reg(RegMinPoints, 16'd0);
    write_reg(RegRepeat, 16'd0);
    write_reg(RegCountMisses, 16'd0);
    setting_cnt++;
    add_sample(16'd0, 1'b1, 1'b1);
    add_sample(16'hFFFF, 1'b1, 1'b0);
    add_sample(16'hFFFF, 1'b1, 1'b0);
    add_sample(16'd1, 1'b0, 1'b0);
    add_sample(16'hFFFF, 1'b1, 1'b1);
    wait_idle();

    // Miss mode, angle wraps through zero
    write_reg(RegMinPoints, 16'd2);
    write_reg(RegRepeat, 16'd1);
    write_reg(RegCountMisses, 16'd1);
    write_reg(RegScanStart, 16'h7FFF);
    write_reg(RegScanStep, 16'd0);
    write_reg(RegRegionAngle, 16'h8000);
    setting_cnt++;
    add_sample(16'hFFFE, 1'b1, 1'b0);
    add_sample(16'd0, 1'b1, 1'b1);
    add_sample(16'd200, 1'b1, 1'b1);
    add_sample(16'hFFFF, 1'b0, 1'b1);
    wait_idle();

    // Zero-size region against the largest threshold
    write_reg(RegLength, 16'd0);
    write_reg(RegWidth, 16'd0);
    write_reg(RegMinPoints, 16'd4096);
    write_reg(RegRepeat, 16'd255);
    write_reg(RegCountMisses, 16'd0);
    setting_cnt++;
    add_sample(16'd5, 1'b1, 1'b1);
    add_sample(16'd0, 1'b0, 1'b1);
    wait_idle();

    // Streak saturation: one-word scans that all hit, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(RegMinPoints, 16'd0);
    write_reg(RegLength, pick_setting(RegLength));
    write_reg(RegWidth, pick_setting(RegWidth));
    write_reg(RegScanStep, pick_setting(RegScanStep));
    setting_cnt++;
    for (int n = 0; n < 262; n++) add_sample(16'($urandom), 1'($urandom), 1'b1);
    wait_idle();
    send_idle_pct = 33;
    recv_idle_pct = 33;

    // Random scans; a phase may stop mid-scan so the next writes land inside it
    random_items = 0;
    while (random_items < RandomItems) begin
      shuffle_settings();
      repeat ($urandom_range(2, 10)) begin
        scan_len = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 120) :
                   $urandom_range(1, 30);
        for (int n = 0; n < scan_len; n++) begin
          add_sample(pick_range(), $urandom_range(0, 99) < 85, n == scan_len - 1);
        end
        random_items += scan_len;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) add_sample(pick_range(), 1'b1, 1'b0);
      end
      wait_idle();
    end
    // close any scan left open
    add_sample(pick_range(), 1'b1, 1'b1);
    wait_idle();

    $display("Sent %0d sample words over %0d register settings; %0d scan results compared.",
             accepted_cnt, setting_cnt, scans_checked);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/lrod_pkg.sv
rtl/lrod_cfg.sv
rtl/lrod_geom.sv
rtl/lrod_eval.sv
rtl/lidar_region_obstacle_detect.sv
tb/sv/tb_lidar_region_obstacle_detect.sv
